/* rtl/core/i2cra_pkg.sv */
// Package for the I2C register access master: item types, action codes, register indexes and reset values.
`timescale 1ns / 1ps

package i2cra_pkg;

	localparam int CFG_INDEX_W = 1;
	localparam int CFG_DATA_W  = 16;

	localparam logic [CFG_INDEX_W-1:0] CFG_DEVICE_ADDRESS = 1'd0;
	localparam logic [CFG_INDEX_W-1:0] CFG_TICKS_PER_UNIT = 1'd1;

	localparam logic [6:0]  DEVICE_ADDRESS_RESET = 7'd90;
	localparam logic [15:0] TICKS_PER_UNIT_RESET = 16'd50;

	localparam logic [1:0] ACT_TICK  = 2'd0;
	localparam logic [1:0] ACT_WRITE = 2'd1;
	localparam logic [1:0] ACT_READ  = 2'd2;

	typedef struct packed {
		logic [1:0] action;
		logic [7:0] reg_addr;
		logic [7:0] write_data;
		logic       sda_in;
	} i2cra_in_t;

	typedef struct packed {
		logic       scl_release;
		logic       sda_release;
		logic       busy_res;
		logic       done_res;
		logic       nack_error;
		logic [7:0] read_data;
	} i2cra_out_t;

endpackage

/* rtl/core/i2c_register_access_master_top.sv */
// Top level of the bit-banged I2C master for single-register reads and writes.
`timescale 1ns / 1ps

// Each accepted item is one tick of elapsed time and yields exactly one result item.
// An item is registered on entry, then one pass of logic advances the bus sequencer and
// fills the result register, so one item is taken every cycle while the output is not stalled,
// and its result passes through the input stage and then the result register; the result register and
// its stall alone set the throughput. Writes to the
// configuration port are always accepted and should be made only while no transaction runs.
// A request (action 1 write, 2 read) is taken only while idle; bus timing is counted in
// delay units of ticks_per_unit items each, a value of zero counting as one.
module i2c_register_access_master_top (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_stall,
	input  i2cra_pkg::i2cra_in_t              in_data,
	output logic                              out_valid,
	input  logic                              out_stall,
	output i2cra_pkg::i2cra_out_t             out_data,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [i2cra_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  logic [i2cra_pkg::CFG_DATA_W-1:0]  cfg_data
);
	import i2cra_pkg::*;

	typedef enum logic [4:0] {
		PH_IDLE, PH_S0, PH_S1, PH_S2, PH_W0, PH_W1, PH_W2, PH_WA0, PH_WA1, PH_WA2,
		PH_WA3, PH_R0, PH_R1, PH_RA0, PH_RA1, PH_RA2, PH_RA3, PH_RA4, PH_GAP,
		PH_T0, PH_T1, PH_T2
	} phase_t;

	function automatic logic [3:0] phase_units(input phase_t p);
		logic [3:0] u;
		case (p)
			PH_S0: u = 4'd10;
			PH_S1, PH_S2, PH_GAP, PH_T0, PH_T1, PH_T2: u = 4'd4;
			PH_W2, PH_WA2, PH_WA3, PH_R0, PH_R1, PH_RA2: u = 4'd2;
			PH_W0, PH_W1, PH_WA0, PH_WA1, PH_RA0, PH_RA1, PH_RA3, PH_RA4: u = 4'd1;
			default: u = 4'd0;
		endcase
		return u;
	endfunction

	// Configuration registers
	logic [6:0]  device_address_q;
	logic [15:0] ticks_per_unit_q;

	// Input stage
	logic      in_valid_s1;
	i2cra_in_t in_data_s1;

	// Sequencer state
	phase_t     phase_q;
	logic [15:0] tick_count_q;
	logic [3:0]  unit_count_q;
	logic [3:0]  bit_count_q;
	logic [7:0]  shift_byte_q;
	logic [2:0]  byte_index_q;
	logic        is_read_q;
	logic [7:0]  latched_reg_q;
	logic [7:0]  latched_data_q;
	logic        error_flag_q;
	logic [7:0]  read_byte_q;
	logic        scl_level_q;
	logic        sda_level_q;

	logic       out_valid_q;
	i2cra_out_t out_data_q;

	// Next-state values
	phase_t      phase_d;
	logic [15:0] tick_count_d;
	logic [3:0]  unit_count_d;
	logic [3:0]  bit_count_d;
	logic [7:0]  shift_byte_d;
	logic [2:0]  byte_index_d;
	logic        is_read_d;
	logic [7:0]  latched_reg_d;
	logic [7:0]  latched_data_d;
	logic        error_flag_d;
	logic [7:0]  read_byte_d;
	logic        scl_level_d;
	logic        sda_level_d;
	logic        done_d;
	logic        enter_d;
	logic [15:0] tpu;
	logic        advance;
	logic        step;

	assign advance   = !out_valid_q || !out_stall;
	assign step      = in_valid_s1 && advance;
	assign in_stall  = in_valid_s1 && !advance;
	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;
	assign cfg_ready = 1'b1;
	assign tpu       = (ticks_per_unit_q == 16'd0) ? 16'd1 : ticks_per_unit_q;

	always_comb begin
		phase_d        = phase_q;
		tick_count_d   = tick_count_q;
		unit_count_d   = unit_count_q;
		bit_count_d    = bit_count_q;
		shift_byte_d   = shift_byte_q;
		byte_index_d   = byte_index_q;
		is_read_d      = is_read_q;
		latched_reg_d  = latched_reg_q;
		latched_data_d = latched_data_q;
		error_flag_d   = error_flag_q;
		read_byte_d    = read_byte_q;
		scl_level_d    = scl_level_q;
		sda_level_d    = sda_level_q;
		done_d         = 1'b0;
		enter_d        = 1'b0;

		if (phase_q == PH_IDLE) begin
			if (in_data_s1.action == ACT_WRITE || in_data_s1.action == ACT_READ) begin
				latched_reg_d  = in_data_s1.reg_addr;
				latched_data_d = in_data_s1.write_data;
				is_read_d      = (in_data_s1.action == ACT_READ);
				error_flag_d   = 1'b0;
				byte_index_d   = 3'd0;
				bit_count_d    = 4'd0;
				phase_d        = PH_S0;
				enter_d        = 1'b1;
			end
		end else begin
			tick_count_d = tick_count_q + 16'd1;
			if (tick_count_d >= tpu) begin
				tick_count_d = 16'd0;
				unit_count_d = unit_count_q + 4'd1;
				if (unit_count_d >= phase_units(phase_q)) begin
					// The current phase ends here; choose and enter the next one.
					enter_d = 1'b1;
					case (phase_q)
						PH_S2: begin
							shift_byte_d = {device_address_q, byte_index_q == 3'd2};
							bit_count_d  = 4'd0;
							phase_d      = PH_W0;
						end
						PH_W2: begin
							shift_byte_d = {shift_byte_q[6:0], 1'b0};
							bit_count_d  = bit_count_q + 4'd1;
							phase_d      = (bit_count_d >= 4'd8) ? PH_WA0 : PH_W0;
						end
						PH_WA2: begin
							if (in_data_s1.sda_in) begin
								error_flag_d = 1'b1;
							end
							phase_d = PH_WA3;
						end
						PH_WA3: begin
							phase_d = error_flag_q ? PH_T0 : PH_GAP;
						end
						PH_R1: begin
							shift_byte_d = {shift_byte_q[6:0], in_data_s1.sda_in};
							bit_count_d  = bit_count_q + 4'd1;
							phase_d      = (bit_count_d >= 4'd8) ? PH_RA0 : PH_R0;
						end
						PH_RA4: begin
							phase_d = PH_GAP;
						end
						PH_GAP: begin
							byte_index_d = byte_index_q + 3'd1;
							if (byte_index_d == 3'd1) begin
								shift_byte_d = latched_reg_q;
								bit_count_d  = 4'd0;
								phase_d      = PH_W0;
							end else if (!is_read_q) begin
								if (byte_index_d == 3'd2) begin
									shift_byte_d = latched_data_q;
									bit_count_d  = 4'd0;
									phase_d      = PH_W0;
								end else begin
									phase_d = PH_T0;
								end
							end else if (byte_index_d == 3'd3) begin
								shift_byte_d = 8'd0;
								bit_count_d  = 4'd0;
								phase_d      = PH_R0;
							end else begin
								phase_d = PH_T0;
							end
						end
						PH_T2: begin
							// After the register byte of a read, a stop and then a new start follow.
							if (is_read_q && byte_index_q == 3'd2 && !error_flag_q) begin
								phase_d = PH_S0;
							end else begin
								if (is_read_q && !error_flag_q) begin
									read_byte_d = shift_byte_q;
								end
								phase_d = PH_IDLE;
								done_d  = 1'b1;
							end
						end
						PH_S0, PH_S1, PH_W0, PH_W1, PH_WA0, PH_WA1, PH_R0, PH_RA0,
						PH_RA1, PH_RA2, PH_RA3, PH_T0, PH_T1: begin
							phase_d = phase_t'(phase_q + 5'd1);
						end
						default: begin
							phase_d = PH_IDLE;
						end
					endcase
				end
			end
		end

		// Entering a phase restarts its timing and applies its pin change.
		if (enter_d) begin
			tick_count_d = 16'd0;
			unit_count_d = 4'd0;
			case (phase_d)
				PH_S1, PH_T0, PH_RA1: sda_level_d = 1'b0;
				PH_S2, PH_W0, PH_WA0, PH_WA3, PH_R0, PH_RA0, PH_RA3: scl_level_d = 1'b0;
				PH_W1: sda_level_d = shift_byte_d[7];
				PH_W2, PH_WA2, PH_R1, PH_RA2, PH_T1: scl_level_d = 1'b1;
				PH_WA1, PH_RA4, PH_T2: sda_level_d = 1'b1;
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			device_address_q <= DEVICE_ADDRESS_RESET;
			ticks_per_unit_q <= TICKS_PER_UNIT_RESET;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_DEVICE_ADDRESS: device_address_q <= cfg_data[6:0];
				CFG_TICKS_PER_UNIT: ticks_per_unit_q <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			in_valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!in_stall && in_valid) begin
			in_data_s1 <= in_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q        <= PH_IDLE;
			tick_count_q   <= 16'd0;
			unit_count_q   <= 4'd0;
			bit_count_q    <= 4'd0;
			shift_byte_q   <= 8'd0;
			byte_index_q   <= 3'd0;
			is_read_q      <= 1'b0;
			latched_reg_q  <= 8'd0;
			latched_data_q <= 8'd0;
			error_flag_q   <= 1'b0;
			read_byte_q    <= 8'd0;
			scl_level_q    <= 1'b1;
			sda_level_q    <= 1'b1;
			out_valid_q    <= 1'b0;
			out_data_q     <= '0;
		end else if (step) begin
			phase_q                <= phase_d;
			tick_count_q           <= tick_count_d;
			unit_count_q           <= unit_count_d;
			bit_count_q            <= bit_count_d;
			shift_byte_q           <= shift_byte_d;
			byte_index_q           <= byte_index_d;
			is_read_q              <= is_read_d;
			latched_reg_q          <= latched_reg_d;
			latched_data_q         <= latched_data_d;
			error_flag_q           <= error_flag_d;
			read_byte_q            <= read_byte_d;
			scl_level_q            <= scl_level_d;
			sda_level_q            <= sda_level_d;
			out_valid_q            <= 1'b1;
			out_data_q.scl_release <= scl_level_d;
			out_data_q.sda_release <= sda_level_d;
			out_data_q.busy_res    <= (phase_d != PH_IDLE);
			out_data_q.done_res    <= done_d;
			out_data_q.nack_error  <= error_flag_d;
			out_data_q.read_data   <= read_byte_d;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

endmodule

/* rtl/core/i2cra_checker.sv */
// Port checker for the I2C register access master, bound to its top level.
`timescale 1ns / 1ps

module i2cra_checker (
	input logic                  clk,
	input logic                  arst_n,
	input logic                  in_valid,
	input logic                  in_stall,
	input i2cra_pkg::i2cra_in_t  in_data,
	input logic                  out_valid,
	input logic                  out_stall,
	input i2cra_pkg::i2cra_out_t out_data
);
	import i2cra_pkg::*;

	// An input item that is held back keeps its payload until it is taken.
	assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_stall |=> in_valid && $stable(in_data))
		else $error("input item changed while stalled");

	// A result that is held back stays put until it is taken.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_data))
		else $error("result item changed while stalled");

	// The completing tick already reports the bus as free.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.done_res |-> !out_data.busy_res)
		else $error("done reported while still busy");

	// With no transaction running both lines are released.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_data.busy_res |-> out_data.scl_release && out_data.sda_release)
		else $error("bus line driven low while idle");

	// Read data only changes on the item that completes a transaction.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_stall ##1 out_valid && !out_data.done_res
		|-> out_data.read_data == $past(out_data.read_data))
		else $error("read data changed outside a completion");

endmodule

bind i2c_register_access_master_top i2cra_checker u_i2cra_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_stall  (in_stall),
	.in_data   (in_data),
	.out_valid (out_valid),
	.out_stall (out_stall),
	.out_data  (out_data)
);
